// File: src/fls_pkg.sv
package fls_pkg;

    localparam int COORD_W = 20;
    localparam int DEN_W   = 42;   // divider remainder / divisor width
    localparam int LO_W    = 41;   // dividend bits shifted in, MSB first
    localparam int QUO_W   = 41;
    localparam int ITER_W  = 6;
    localparam int ROOT_IN_W = 61;
    localparam int ROOT_W  = 31;

    typedef enum logic [2:0] {
        CFG_WIN_W  = 3'd0,
        CFG_WIN_H  = 3'd1,
        CFG_MARGIN = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_RADIUS = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_SQ, S_D2, S_DIV, S_ACC, S_NORM, S_SHIFT, S_SQ2,
        S_SUM2, S_SQRT, S_MUL, S_DIV2, S_DIVW2, S_MOVE, S_RFETCH, S_RSQ,
        S_RCMP, S_DONE
    } t_state;

    typedef struct packed {
        logic               valid;
        logic               sign;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_charge;

    typedef struct packed {
        logic [DEN_W-1:0]  rem0;
        logic [DEN_W-1:0]  den;
        logic [LO_W-1:0]   lo;
        logic [ITER_W-1:0] iters;
    } t_div_req;

endpackage

// File: src/field_line_trace_step.sv
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready   tuser: mode; tdata: slot, x, y, pol, present
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready   tdata: next_x, next_y, stop
// cfg       in   i_cfg_we (no wait)                 i_cfg_addr, i_cfg_wdata
//
// A load request writes the addressed charge slot and returns nothing.
// A step request runs pass one over every charge slot (a serial divide per valid charge
// dominates; an empty slot or a charge at the point is skipped), then normalize, a serial
// square root, a second serial divide, the move and a capture scan over every slot; a zero
// resultant goes from normalize straight to the result with stop set.
// Synchronous active-low reset clears the charge ring and loads register defaults.
// One request in flight; a finished result sits in the output register, so a stalled
// m_axis holds only the next step's final write-back.
module field_line_trace_step
    import fls_pkg::*;
#(
    parameter int MAX_CHARGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [3:0] slot, [23:4] point_x, [43:24] point_y,
                                          // [44] polarity, [45] present, rest zero
    input  logic        i_s_axis_tuser,   // [0] mode: 0 load, 1 step
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [19:0] next_x, [39:20] next_y, [40] stop
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata
);

    localparam int CW    = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int ACC_W = 43 + CW;

    // configuration
    logic [10:0] r_win_w, r_win_h;
    logic [7:0]  r_margin, r_radius;
    logic [11:0] r_step;

    t_state r_state, n_state;

    // input fields
    logic [3:0]  w_slot;
    logic [19:0] w_px, w_py;
    assign w_slot = i_s_axis_tdata[3:0];
    assign w_px   = i_s_axis_tdata[23:4];
    assign w_py   = i_s_axis_tdata[43:24];

    logic w_acc_in;
    assign w_acc_in = i_s_axis_tvalid && o_s_axis_tready;

    // charge ring: cell 0 is the head, shift moves each entry one place toward it
    t_charge w_cell [MAX_CHARGES];
    t_charge w_wr;
    t_charge w_head;
    logic    w_shift;

    assign w_wr = '{valid: i_s_axis_tdata[45], sign: i_s_axis_tdata[44], x: w_px, y: w_py};
    assign w_head = w_cell[0];

    for (genvar g = 0; g < MAX_CHARGES; g++) begin : g_cell
        fls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_acc_in && !i_s_axis_tuser && (8'(w_slot) == 8'(g))),
            .i_wr    (w_wr),
            .i_shift (w_shift),
            .i_next  (w_cell[(g + 1) % MAX_CHARGES]),
            .o_q     (w_cell[g])
        );
    end

    // step datapath registers
    logic [19:0]              r_px, r_py, r_sx, r_sy, r_nx, r_ny;
    logic [3:0]               r_slot;
    logic [CW-1:0]            r_cnt;
    logic                     r_src_pos, r_stop, r_skip, r_negx, r_negy, r_exn, r_eyn;
    logic [20:0]              r_ux, r_uy;
    logic [41:0]              r_ux2, r_uy2;
    logic signed [ACC_W-1:0]  r_ex, r_ey;
    logic [ACC_W-1:0]         r_ax, r_ay;
    logic [59:0]              r_ax2, r_ay2;
    logic [42:0]              r_mdx, r_mdy;
    logic                     r_out_valid;
    logic [47:0]              r_out_data;

    logic w_last;
    assign w_last = r_cnt == CW'(MAX_CHARGES - 1);

    // serial units
    t_div_req          w_rq_x, w_rq_y;
    logic              w_div_start, w_busy_x, w_busy_y, w_sq_start, w_sq_busy;
    logic [QUO_W-1:0]  w_qx, w_qy;
    logic [ROOT_W-1:0] w_root;

    always_comb begin
        if (r_state == S_DIV2) begin
            w_rq_x = '{rem0: DEN_W'(r_mdx >> 13), den: DEN_W'(w_root),
                       lo: {r_mdx[12:0], 28'b0}, iters: ITER_W'(13)};
            w_rq_y = '{rem0: DEN_W'(r_mdy >> 13), den: DEN_W'(w_root),
                       lo: {r_mdy[12:0], 28'b0}, iters: ITER_W'(13)};
        end else begin
            w_rq_x = '{rem0: DEN_W'(r_ux[19:1]), den: DEN_W'(r_ux2) + DEN_W'(r_uy2),
                       lo: {r_ux[0], 40'b0}, iters: ITER_W'(41)};
            w_rq_y = '{rem0: DEN_W'(r_uy[19:1]), den: DEN_W'(r_ux2) + DEN_W'(r_uy2),
                       lo: {r_uy[0], 40'b0}, iters: ITER_W'(41)};
        end
    end

    fls_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_req(w_rq_x),
        .o_quo(w_qx), .o_busy(w_busy_x)
    );
    fls_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_req(w_rq_y),
        .o_quo(w_qy), .o_busy(w_busy_y)
    );
    fls_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_n(ROOT_IN_W'(r_ax2) + ROOT_IN_W'(r_ay2)), .o_root(w_root), .o_busy(w_sq_busy)
    );

    // pass-one differences (point minus charge)
    logic signed [20:0] w_dx, w_dy, w_rdx, w_rdy;
    assign w_dx  = $signed({r_px[19], r_px}) - $signed({w_head.x[19], w_head.x});
    assign w_dy  = $signed({r_py[19], r_py}) - $signed({w_head.y[19], w_head.y});
    // capture scan differences (charge minus new point)
    assign w_rdx = $signed({w_head.x[19], w_head.x}) - $signed({r_nx[19], r_nx});
    assign w_rdy = $signed({w_head.y[19], w_head.y}) - $signed({r_ny[19], r_ny});

    // normalize
    logic [ACC_W-1:0] w_m;
    logic             w_m_hi, w_m_lo;
    assign w_m    = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_m_hi = w_m[ACC_W-1:30] != '0;
    assign w_m_lo = w_m[ACC_W-1:29] == '0;

    // move and bounds
    logic               w_subx, w_suby, w_satx, w_saty, w_out_win;
    logic signed [21:0] w_nx22, w_ny22, w_lo, w_hix, w_hiy;
    logic [19:0]        w_nxc, w_nyc;
    assign w_subx = r_exn != !r_src_pos;
    assign w_suby = r_eyn != !r_src_pos;
    assign w_nx22 = w_subx ? $signed({{2{r_px[19]}}, r_px}) - $signed({9'b0, w_qx[12:0]})
                           : $signed({{2{r_px[19]}}, r_px}) + $signed({9'b0, w_qx[12:0]});
    assign w_ny22 = w_suby ? $signed({{2{r_py[19]}}, r_py}) - $signed({9'b0, w_qy[12:0]})
                           : $signed({{2{r_py[19]}}, r_py}) + $signed({9'b0, w_qy[12:0]});
    assign w_satx = (w_nx22 > 22'sd524287) || (w_nx22 < -22'sd524288);
    assign w_saty = (w_ny22 > 22'sd524287) || (w_ny22 < -22'sd524288);
    assign w_nxc  = (w_nx22 > 22'sd524287) ? 20'h7FFFF :
                    (w_nx22 < -22'sd524288) ? 20'h80000 : w_nx22[19:0];
    assign w_nyc  = (w_ny22 > 22'sd524287) ? 20'h7FFFF :
                    (w_ny22 < -22'sd524288) ? 20'h80000 : w_ny22[19:0];
    assign w_lo   = -$signed({6'b0, r_margin, 8'b0});
    assign w_hix  = $signed({2'b0, 12'(r_win_w) + 12'(r_margin), 8'b0});
    assign w_hiy  = $signed({2'b0, 12'(r_win_h) + 12'(r_margin), 8'b0});
    assign w_out_win = !($signed({{2{w_nxc[19]}}, w_nxc}) > w_lo
                      && $signed({{2{w_nxc[19]}}, w_nxc}) < w_hix
                      && $signed({{2{w_nyc[19]}}, w_nyc}) > w_lo
                      && $signed({{2{w_nyc[19]}}, w_nyc}) < w_hiy);

    logic [31:0] w_r2lim;
    assign w_r2lim = {16'(r_radius) * 16'(r_radius), 16'b0};

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_acc_in && i_s_axis_tuser) n_state = S_FETCH;
            S_FETCH:  n_state = S_SQ;
            S_SQ:     n_state = r_skip ? S_ACC : S_D2;
            S_D2:     n_state = S_DIV;
            S_DIV:    if (!w_busy_x && !w_busy_y) n_state = S_ACC;
            S_ACC:    n_state = w_last ? S_NORM : S_FETCH;
            S_NORM:   n_state = (r_ex == '0 && r_ey == '0) ? S_DONE : S_SHIFT;
            S_SHIFT:  if (!w_m_hi && !w_m_lo) n_state = S_SQ2;
            S_SQ2:    n_state = S_SUM2;
            S_SUM2:   n_state = S_SQRT;
            S_SQRT:   if (!w_sq_busy) n_state = S_MUL;
            S_MUL:    n_state = S_DIV2;
            S_DIV2:   n_state = S_DIVW2;
            S_DIVW2:  if (!w_busy_x && !w_busy_y) n_state = S_MOVE;
            S_MOVE:   n_state = S_RFETCH;
            S_RFETCH: n_state = S_RSQ;
            S_RSQ:    n_state = S_RCMP;
            S_RCMP:   n_state = w_last ? S_DONE : S_RFETCH;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_shift         = 1'b0;
        w_div_start     = 1'b0;
        w_sq_start      = 1'b0;
        unique case (r_state)
            S_IDLE:          o_s_axis_tready = 1'b1;
            S_ACC, S_RCMP:   w_shift = 1'b1;
            S_D2, S_DIV2:    w_div_start = 1'b1;
            S_SUM2:          w_sq_start = 1'b1;
            default:         ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_win_w     <= 11'd800;
            r_win_h     <= 11'd600;
            r_margin    <= 8'd0;
            r_step      <= 12'd1280;
            r_radius    <= 8'd20;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_WIN_W:  r_win_w  <= i_cfg_wdata[10:0];
                    CFG_WIN_H:  r_win_h  <= i_cfg_wdata[10:0];
                    CFG_MARGIN: r_margin <= i_cfg_wdata[7:0];
                    CFG_STEP:   r_step   <= i_cfg_wdata;
                    CFG_RADIUS: r_radius <= i_cfg_wdata[7:0];
                    default:    ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px      <= w_px;
                r_py      <= w_py;
                r_slot    <= w_slot;
                r_cnt     <= '0;
                r_ex      <= '0;
                r_ey      <= '0;
                r_sx      <= '0;
                r_sy      <= '0;
                r_src_pos <= 1'b0;
                r_stop    <= 1'b0;
            end
            S_FETCH: begin
                r_ux   <= 21'(w_dx[20] ? -w_dx : w_dx);
                r_uy   <= 21'(w_dy[20] ? -w_dy : w_dy);
                r_negx <= w_dx[20] ^ !w_head.sign;
                r_negy <= w_dy[20] ^ !w_head.sign;
                r_skip <= !w_head.valid || (w_dx == '0 && w_dy == '0);
                if (8'(r_slot) == 8'(r_cnt)) begin
                    r_sx      <= w_head.x;
                    r_sy      <= w_head.y;
                    r_src_pos <= w_head.sign;
                end
            end
            S_SQ, S_RSQ: begin
                r_ux2 <= r_ux * r_ux;
                r_uy2 <= r_uy * r_uy;
            end
            S_ACC: begin
                if (!r_skip) begin
                    r_ex <= r_negx ? r_ex - $signed(ACC_W'(w_qx)) : r_ex + $signed(ACC_W'(w_qx));
                    r_ey <= r_negy ? r_ey - $signed(ACC_W'(w_qy)) : r_ey + $signed(ACC_W'(w_qy));
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_NORM: begin
                r_ax  <= ACC_W'(r_ex[ACC_W-1] ? -r_ex : r_ex);
                r_ay  <= ACC_W'(r_ey[ACC_W-1] ? -r_ey : r_ey);
                r_exn <= r_ex[ACC_W-1];
                r_eyn <= r_ey[ACC_W-1];
                r_nx  <= r_px;
                r_ny  <= r_py;
                r_stop <= 1'b1;   // kept only on a zero resultant
            end
            S_SHIFT: begin
                if (w_m_hi) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else if (w_m_lo) begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            S_SQ2: begin
                r_ax2 <= r_ax[29:0] * r_ax[29:0];
                r_ay2 <= r_ay[29:0] * r_ay[29:0];
            end
            S_MUL: begin
                r_mdx <= 43'(r_step * r_ax[29:0]) + 43'(w_root >> 1);
                r_mdy <= 43'(r_step * r_ay[29:0]) + 43'(w_root >> 1);
            end
            S_MOVE: begin
                r_nx   <= w_nxc;
                r_ny   <= w_nyc;
                r_stop <= w_satx || w_saty || w_out_win;
                r_cnt  <= '0;
            end
            S_RFETCH: begin
                r_ux   <= 21'(w_rdx[20] ? -w_rdx : w_rdx);
                r_uy   <= 21'(w_rdy[20] ? -w_rdy : w_rdy);
                r_skip <= !w_head.valid || (w_head.x == r_sx && w_head.y == r_sy);
            end
            S_RCMP: begin
                if (!r_skip && (43'(r_ux2) + 43'(r_uy2) <= 43'(w_r2lim))) begin
                    r_stop <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= {7'b0, r_stop, r_ny, r_nx};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: src/fls_cell.sv
module fls_cell
    import fls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_we,
    input  t_charge i_wr,     // valid carries the present flag
    input  logic    i_shift,
    input  t_charge i_next,
    output t_charge o_q
);

    t_charge r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_next;
        end else if (i_we) begin
            if (i_wr.valid) begin
                r_q <= i_wr;
            end else begin
                r_q.valid <= 1'b0;
            end
        end
    end

    assign o_q = r_q;

endmodule

// File: src/fls_div.sv
module fls_div
    import fls_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_div_req         i_req,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_busy
);

    logic [ITER_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [LO_W-1:0]   r_lo;
    logic [QUO_W-1:0]  r_quo;
    logic [DEN_W:0]    w_t;
    logic              w_ge;

    assign w_t  = {r_rem, r_lo[LO_W-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_req.iters;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_req.rem0;
            r_den <= i_req.den;
            r_lo  <= i_req.lo;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : DEN_W'(w_t);
            r_lo  <= {r_lo[LO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_cnt != '0;

endmodule

// File: src/fls_sqrt.sv
module fls_sqrt
    import fls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ROOT_IN_W-1:0] i_n,
    output logic [ROOT_W-1:0]    o_root,
    output logic                 o_busy
);

    logic [ROOT_IN_W-1:0] r_bit;
    logic [ROOT_IN_W-1:0] r_n;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W:0]   w_try;

    assign w_try = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= ROOT_IN_W'(1) << (ROOT_IN_W - 1);
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if ({1'b0, r_n} >= w_try) begin
                r_n   <= ROOT_IN_W'({1'b0, r_n} - w_try);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_busy = r_bit != '0;

endmodule

// File: src/fls_chk.sv
module fls_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a step request closes the input right after it is accepted
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("input open right after step request");

    // a load request never produces a result next cycle from nothing
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser && !o_m_axis_tvalid)
        |=> !o_m_axis_tvalid)
        else $error("result after load request");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind field_line_trace_step fls_chk u_fls_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
